>>> rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the spring/damper force block
// Word layouts, register indexes, fixed-point formats and derived widths.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // fixed-point formats
  localparam int COORD_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_BITS     = 32;
  localparam int FORCE_BITS   = 48;
  localparam int CFG_IDX_BITS = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_K_STRETCH    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_K_COMPRESS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING_GAIN = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REST_LENGTH  = 2'd3;

  // stiffness reset value: 100.0
  localparam logic [CFG_BITS-1:0] K_RESET = CFG_BITS'(100 << FRAC_BITS);

  // derived widths
  localparam int DW   = COORD_BITS + 1;          // coordinate difference
  localparam int DDW  = 2 * COORD_BITS + 4;      // squared length
  localparam int LW   = DDW / 2;                 // length
  localparam int VW   = DDW;                     // |relative velocity . d|
  localparam int SMW  = (LW > CFG_BITS) ? LW : CFG_BITS; // |length - rest|
  localparam int QDW  = 64;                      // damping quotient
  localparam int PW   = 64 + DW;                 // |t| * |d_i|
  localparam int FQW  = FORCE_BITS;              // force quotient

  // input word
  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_pos_x;
    logic signed [COORD_BITS-1:0] a_pos_y;
    logic signed [COORD_BITS-1:0] a_pos_z;
    logic signed [COORD_BITS-1:0] b_pos_x;
    logic signed [COORD_BITS-1:0] b_pos_y;
    logic signed [COORD_BITS-1:0] b_pos_z;
    logic signed [COORD_BITS-1:0] a_vel_x;
    logic signed [COORD_BITS-1:0] a_vel_y;
    logic signed [COORD_BITS-1:0] a_vel_z;
    logic signed [COORD_BITS-1:0] b_vel_x;
    logic signed [COORD_BITS-1:0] b_vel_y;
    logic signed [COORD_BITS-1:0] b_vel_z;
  } sdf_in_t;

  // result word
  typedef struct packed {
    logic signed [FORCE_BITS-1:0] force_x;
    logic signed [FORCE_BITS-1:0] force_y;
    logic signed [FORCE_BITS-1:0] force_z;
    logic                         applied;
    logic                         degenerate;
    logic                         stretched;
  } sdf_out_t;

endpackage

>>> rtl/spring_damper_force_top.sv
// ----------------------------------------------------------------------------
// spring_damper_force_top: spring/damper force between two attachment points
// Fixed-point spring force with damping along the separation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one word: both points' positions and
//   velocities. out_valid/out_stall/out_data return the force on the first
//   body (the second body gets its negation) plus applied/degenerate/
//   stretched flags. A word moves at an edge with valid high and stall low.
//   cfg_we/cfg_addr/cfg_wdata write the four registers; write them only
//   while no word is in flight.
// Timing:
//   one word per cycle while no result waits under out_stall. The pipeline
//   has 3 input stages, 34 square-root stages, 2 stages, 64 damping-quotient
//   stages, 8 stages, 48 force-quotient stages and the output register. The
//   depth is set by the bit-per-stage square root and the two restoring dividers.
// Reset and stall:
//   synchronous reset empties the pipeline and loads the register defaults.
//   While a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module spring_damper_force_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sdf_pkg::sdf_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sdf_pkg::sdf_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [sdf_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
  input  logic [sdf_pkg::CFG_BITS-1:0]      cfg_wdata
);

  import sdf_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam logic [61:0] LIM62 = '1;
  localparam logic [FQW-1:0] F_POS_LIM = {1'b0, {(FQW-1){1'b1}}};
  localparam logic [FQW-1:0] F_NEG_LIM = {1'b1, {(FQW-1){1'b0}}};

  // side words
  typedef struct packed {
    logic [2:0][DW-1:0] dmag;
    logic [2:0]         dneg;
    logic signed [VW:0] vd;
    logic               degen;
  } sq_side_t;

  typedef struct packed {
    logic [LW-1:0]      len;
    logic [2:0][DW-1:0] dmag;
    logic [2:0]         dneg;
    logic               stretched;
    logic               degen;
  } carry_t;

  typedef struct packed {
    logic [2*SMW-1:0] s2;
    logic             qovf;
    logic             qneg;
    carry_t           c;
  } q_side_t;

  typedef struct packed {
    logic [2:0] fovf;
    logic [2:0] fneg;
    logic       stretched;
    logic       degen;
  } f_side_t;

  // configuration registers
  logic [CFG_BITS-1:0] k_stretch_r, k_compress_r, damping_gain_r, rest_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_stretch_r    <= K_RESET;
      k_compress_r   <= K_RESET;
      damping_gain_r <= '0;
      rest_length_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_K_STRETCH:    k_stretch_r    <= cfg_wdata;
        REG_K_COMPRESS:   k_compress_r   <= cfg_wdata;
        REG_DAMPING_GAIN: damping_gain_r <= cfg_wdata;
        REG_REST_LENGTH:  rest_length_r  <= cfg_wdata;
      endcase
    end
  end

  // global advance: hold everything while the output word is stalled
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 1: differences
  logic signed [CW-1:0] pa [3], pb [3], va [3], vb [3];
  assign pa[0] = in_data.a_pos_x;  assign pa[1] = in_data.a_pos_y;
  assign pa[2] = in_data.a_pos_z;  assign pb[0] = in_data.b_pos_x;
  assign pb[1] = in_data.b_pos_y;  assign pb[2] = in_data.b_pos_z;
  assign va[0] = in_data.a_vel_x;  assign va[1] = in_data.a_vel_y;
  assign va[2] = in_data.a_vel_z;  assign vb[0] = in_data.b_vel_x;
  assign vb[1] = in_data.b_vel_y;  assign vb[2] = in_data.b_vel_z;

  logic                 s1_valid_r;
  logic signed [DW-1:0] s1_d_r [3], s1_v_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i] <= DW'(pb[i]) - DW'(pa[i]);
        s1_v_r[i] <= DW'(vb[i]) - DW'(va[i]);
      end
    end
  end

  // stage 2: squares and velocity products
  logic                   s2_valid_r;
  logic signed [2*DW-1:0] s2_dd_r [3], s2_vd_r [3];
  logic [2:0][DW-1:0]     s2_dmag_r;
  logic [2:0]             s2_dneg_r;
  logic                   s2_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd_r[i]   <= s1_d_r[i] * s1_d_r[i];
        s2_vd_r[i]   <= s1_v_r[i] * s1_d_r[i];
        s2_dmag_r[i] <= s1_d_r[i][DW-1] ? DW'(-s1_d_r[i]) : DW'(s1_d_r[i]);
        s2_dneg_r[i] <= s1_d_r[i][DW-1];
      end
      s2_degen_r <= (s1_d_r[0] == '0) && (s1_d_r[1] == '0) && (s1_d_r[2] == '0);
    end
  end

  // stage 3: sums
  logic           s3_valid_r;
  logic [DDW-1:0] s3_dd_r;
  sq_side_t       s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dd_r <= DDW'(s2_dd_r[0]) + DDW'(s2_dd_r[1]) + DDW'(s2_dd_r[2]);
      s3_side_r.vd <= (VW+1)'(s2_vd_r[0]) + (VW+1)'(s2_vd_r[1]) + (VW+1)'(s2_vd_r[2]);
      s3_side_r.dmag  <= s2_dmag_r;
      s3_side_r.dneg  <= s2_dneg_r;
      s3_side_r.degen <= s2_degen_r;
    end
  end

  // length
  logic          sq_valid;
  logic [LW-1:0] sq_len;
  sq_side_t      sq_side;

  sdf_sqrt #(
    .XW  (DDW),
    .SBW ($bits(sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .in_x      (s3_dd_r),
    .in_side   (s3_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_len),
    .out_side  (sq_side)
  );

  // stage 4: branch, stretch magnitude, velocity magnitude
  logic           s4_valid_r;
  logic [SMW-1:0] s4_smag_r;
  logic [VW-1:0]  s4_vmag_r;
  logic           s4_qneg_r;
  carry_t         s4_c_r;
  logic [SMW-1:0] len_e, rest_e;
  logic           stretched_nxt;

  assign len_e         = SMW'(sq_len);
  assign rest_e        = SMW'(rest_length_r);
  assign stretched_nxt = len_e > rest_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_smag_r <= stretched_nxt ? len_e - rest_e : rest_e - len_e;
      s4_vmag_r <= sq_side.vd[VW] ? VW'(-sq_side.vd) : VW'(sq_side.vd);
      s4_qneg_r <= sq_side.vd[VW];
      s4_c_r.len       <= sq_len;
      s4_c_r.dmag      <= sq_side.dmag;
      s4_c_r.dneg      <= sq_side.dneg;
      s4_c_r.stretched <= stretched_nxt;
      s4_c_r.degen     <= sq_side.degen;
    end
  end

  // stage 5: stretch square, damping quotient setup
  logic              s5_valid_r;
  logic [LW-1:0]     s5_rem_r;
  logic [QDW-1:0]    s5_low_r;
  q_side_t           s5_side_r;
  logic [VW+QDW-1:0] vm_ext;
  logic [VW-1:0]     vm_hi;
  logic              qovf_nxt;

  assign vm_ext   = (VW+QDW)'(s4_vmag_r);
  assign vm_hi    = vm_ext[VW+QDW-1:QDW];
  assign qovf_nxt = vm_hi >= VW'(s4_c_r.len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rem_r       <= qovf_nxt ? '0 : vm_hi[LW-1:0];
      s5_low_r       <= vm_ext[QDW-1:0];
      s5_side_r.s2   <= s4_smag_r * s4_smag_r;
      s5_side_r.qovf <= qovf_nxt;
      s5_side_r.qneg <= s4_qneg_r;
      s5_side_r.c    <= s4_c_r;
    end
  end

  // damping quotient |v . d| / L
  logic                  qd_valid;
  logic [0:0][QDW-1:0]   qd_quo;
  q_side_t               qd_side;

  sdf_div #(
    .NL  (1),
    .QW  (QDW),
    .DVW (LW),
    .SBW ($bits(q_side_t))
  ) u_qdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_valid_r),
    .in_rem    (s5_rem_r),
    .in_low    (s5_low_r),
    .in_div    (s5_side_r.c.len),
    .in_side   (s5_side_r),
    .out_valid (qd_valid),
    .out_quo   (qd_quo),
    .out_side  (qd_side)
  );

  // stage 7: saturate the stretch square, select the damping quotient
  logic                 s7_valid_r;
  logic [63:0]          s7_sq_r, s7_qm_r;
  logic                 s7_qneg_r;
  carry_t               s7_c_r;
  logic [2*SMW+63:0]    s2_ext;

  assign s2_ext = (2*SMW+64)'(qd_side.s2 >> F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s7_valid_r <= qd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sq_r   <= (|s2_ext[2*SMW+63:64]) ? '1 : s2_ext[63:0];
      s7_qm_r   <= qd_side.qovf ? '1 : qd_quo[0];
      s7_qneg_r <= qd_side.qneg;
      s7_c_r    <= qd_side.c;
    end
  end

  // stage 8: partial products of k * sq and gain * q
  logic          s8_valid_r;
  logic [63:0]   s8_pm_lo_r, s8_pm_hi_r, s8_pg_lo_r, s8_pg_hi_r;
  logic          s8_qneg_r;
  carry_t        s8_c_r;
  logic [31:0]   k_sel;

  assign k_sel = s7_c_r.stretched ? k_stretch_r : k_compress_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else if (en) begin
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_pm_lo_r <= s7_sq_r[31:0] * k_sel;
      s8_pm_hi_r <= s7_sq_r[63:32] * k_sel;
      s8_pg_lo_r <= s7_qm_r[31:0] * damping_gain_r;
      s8_pg_hi_r <= s7_qm_r[63:32] * damping_gain_r;
      s8_qneg_r  <= s7_qneg_r;
      s8_c_r     <= s7_c_r;
    end
  end

  // stage 9: spring and damping magnitudes, scaled and saturated
  logic        s9_valid_r;
  logic [61:0] s9_m_r, s9_gm_r;
  logic        s9_qneg_r;
  carry_t      s9_c_r;
  logic [95:0] m_sh, g_sh;

  assign m_sh = (({s8_pm_hi_r, 32'b0}) + 96'(s8_pm_lo_r)) >> F;
  assign g_sh = (({s8_pg_hi_r, 32'b0}) + 96'(s8_pg_lo_r)) >> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_valid_r <= 1'b0;
    end else if (en) begin
      s9_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_m_r    <= (|m_sh[95:62]) ? LIM62 : m_sh[61:0];
      s9_gm_r   <= (|g_sh[95:62]) ? LIM62 : g_sh[61:0];
      s9_qneg_r <= s8_qneg_r;
      s9_c_r    <= s8_c_r;
    end
  end

  // stage 10: scalar t = m - signed damping
  logic               s10_valid_r;
  logic signed [63:0] s10_t_r;
  carry_t             s10_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_valid_r <= 1'b0;
    end else if (en) begin
      s10_valid_r <= s9_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_t_r <= s9_qneg_r ? $signed(64'(s9_m_r) + 64'(s9_gm_r))
                           : $signed(64'(s9_m_r) - 64'(s9_gm_r));
      s10_c_r <= s9_c_r;
    end
  end

  // stage 11: magnitude of t
  logic        s11_valid_r;
  logic [63:0] s11_tm_r;
  logic        s11_tneg_r;
  carry_t      s11_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_valid_r <= 1'b0;
    end else if (en) begin
      s11_valid_r <= s10_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_tm_r   <= s10_t_r[63] ? 64'(-s10_t_r) : 64'(s10_t_r);
      s11_tneg_r <= s10_t_r[63];
      s11_c_r    <= s10_c_r;
    end
  end

  // stage 12: partial products |t| * |d_i|
  logic             s12_valid_r;
  logic [32+DW-1:0] s12_pf_lo_r [3], s12_pf_hi_r [3];
  logic             s12_tneg_r;
  carry_t           s12_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_valid_r <= 1'b0;
    end else if (en) begin
      s12_valid_r <= s11_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s12_pf_lo_r[i] <= s11_tm_r[31:0] * s11_c_r.dmag[i];
        s12_pf_hi_r[i] <= s11_tm_r[63:32] * s11_c_r.dmag[i];
      end
      s12_tneg_r <= s11_tneg_r;
      s12_c_r    <= s11_c_r;
    end
  end

  // stage 13: full products
  logic          s13_valid_r;
  logic [PW-1:0] s13_p_r [3];
  logic          s13_tneg_r;
  carry_t        s13_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s13_valid_r <= 1'b0;
    end else if (en) begin
      s13_valid_r <= s12_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s13_p_r[i] <= PW'({s12_pf_hi_r[i], 32'b0}) + PW'(s12_pf_lo_r[i]);
      end
      s13_tneg_r <= s12_tneg_r;
      s13_c_r    <= s12_c_r;
    end
  end

  // stage 14: force quotient setup, overflow and sign per axis
  logic                   s14_valid_r;
  logic [2:0][LW-1:0]     s14_rem_r;
  logic [2:0][FQW-1:0]    s14_low_r;
  logic [LW-1:0]          s14_len_r;
  f_side_t                s14_side_r;
  logic [2:0]             fovf_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fovf_nxt[i] = s13_p_r[i][PW-1:FQW] >= (PW-FQW)'(s13_c_r.len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s14_valid_r <= 1'b0;
    end else if (en) begin
      s14_valid_r <= s13_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s14_rem_r[i] <= fovf_nxt[i] ? '0 : s13_p_r[i][FQW +: LW];
        s14_low_r[i] <= s13_p_r[i][FQW-1:0];
        s14_side_r.fneg[i] <= (s13_tneg_r != s13_c_r.dneg[i]) != !s13_c_r.stretched;
      end
      s14_side_r.fovf      <= fovf_nxt;
      s14_side_r.stretched <= s13_c_r.stretched;
      s14_side_r.degen     <= s13_c_r.degen;
      s14_len_r            <= s13_c_r.len;
    end
  end

  // force quotients |t| * |d_i| / L, three axes
  logic                fd_valid;
  logic [2:0][FQW-1:0] fd_quo;
  f_side_t             fd_side;

  sdf_div #(
    .NL  (3),
    .QW  (FQW),
    .DVW (LW),
    .SBW ($bits(f_side_t))
  ) u_fdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s14_valid_r),
    .in_rem    (s14_rem_r),
    .in_low    (s14_low_r),
    .in_div    (s14_len_r),
    .in_side   (s14_side_r),
    .out_valid (fd_valid),
    .out_quo   (fd_quo),
    .out_side  (fd_side)
  );

  // output: saturate, apply sign, zero when off or degenerate
  logic                applied_nxt;
  logic [2:0][FQW-1:0] force_nxt;
  sdf_out_t            out_data_r;

  assign applied_nxt = (fd_side.stretched ? k_stretch_r : k_compress_r) != '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!applied_nxt || fd_side.degen) begin
        force_nxt[i] = '0;
      end else if (fd_side.fneg[i]) begin
        force_nxt[i] = (fd_side.fovf[i] || fd_quo[i] > F_NEG_LIM) ? F_NEG_LIM
                                                                  : FQW'(-fd_quo[i]);
      end else begin
        force_nxt[i] = (fd_side.fovf[i] || fd_quo[i] > F_POS_LIM) ? F_POS_LIM
                                                                  : fd_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.force_x    <= force_nxt[0];
      out_data_r.force_y    <= force_nxt[1];
      out_data_r.force_z    <= force_nxt[2];
      out_data_r.applied    <= applied_nxt;
      out_data_r.degenerate <= fd_side.degen;
      out_data_r.stretched  <= fd_side.stretched;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/sdf_sqrt.sv
// ----------------------------------------------------------------------------
// sdf_sqrt: pipelined integer square root
// Floor square root, one root bit per stage, with a side word carried along.
// ----------------------------------------------------------------------------
module sdf_sqrt #(
  parameter int XW  = 68,
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [XW-1:0]       in_x,
  input  logic [SBW-1:0]      in_side,
  output logic                out_valid,
  output logic [XW/2-1:0]     out_root,
  output logic [SBW-1:0]      out_side
);

  localparam int RW   = XW / 2;
  localparam int REMW = RW + 2;

  logic [RW-1:0]   vld_r;
  logic [XW-1:0]   x_r    [RW];
  logic [RW-1:0]   root_r [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [SBW-1:0]  side_r [RW];

  genvar s;
  for (s = 0; s < RW; s++) begin : g_stage
    logic            v_in;
    logic [XW-1:0]   x_in;
    logic [RW-1:0]   root_in;
    logic [REMW-1:0] rem_in;
    logic [SBW-1:0]  side_in;
    logic [REMW+1:0] tmp;
    logic [REMW+1:0] trial;
    logic [RW-1:0]   root_nxt;
    logic [REMW-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_x;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[s-1];
      assign x_in    = x_r[s-1];
      assign root_in = root_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign side_in = side_r[s-1];
    end

    // one root bit: try (root << 2) | 1 against the next bit pair
    assign tmp   = {rem_in, x_in[XW-1 -: 2]};
    assign trial = (REMW+2)'({root_in, 2'b01});

    always_comb begin
      if (tmp >= trial) begin
        rem_nxt  = REMW'(tmp - trial);
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = tmp[REMW-1:0];
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]    <= x_in << 2;
        root_r[s] <= root_nxt;
        rem_r[s]  <= rem_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

>>> rtl/sdf_div.sv
// ----------------------------------------------------------------------------
// sdf_div: pipelined restoring divider, several lanes sharing one divisor
// One quotient bit per stage; the starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module sdf_div #(
  parameter int NL  = 1,
  parameter int QW  = 64,
  parameter int DVW = 34,
  parameter int SBW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [NL-1:0][DVW-1:0]     in_rem,
  input  logic [NL-1:0][QW-1:0]      in_low,
  input  logic [DVW-1:0]             in_div,
  input  logic [SBW-1:0]             in_side,
  output logic                       out_valid,
  output logic [NL-1:0][QW-1:0]      out_quo,
  output logic [SBW-1:0]             out_side
);

  logic [QW-1:0]              vld_r;
  logic [NL-1:0][DVW-1:0]     rem_r  [QW];
  logic [NL-1:0][QW-1:0]      lq_r   [QW];
  logic [DVW-1:0]             div_r  [QW];
  logic [SBW-1:0]             side_r [QW];

  genvar s;
  for (s = 0; s < QW; s++) begin : g_stage
    logic                   v_in;
    logic [NL-1:0][DVW-1:0] rem_in;
    logic [NL-1:0][QW-1:0]  lq_in;
    logic [DVW-1:0]         div_in;
    logic [SBW-1:0]         side_in;
    logic [NL-1:0][DVW-1:0] rem_nxt;
    logic [NL-1:0][QW-1:0]  lq_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rem;
      assign lq_in   = in_low;
      assign div_in  = in_div;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign lq_in   = lq_r[s-1];
      assign div_in  = div_r[s-1];
      assign side_in = side_r[s-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      logic [DVW:0] trial;
      for (int l = 0; l < NL; l++) begin
        trial = {rem_in[l], lq_in[l][QW-1]};
        if (trial >= {1'b0, div_in}) begin
          rem_nxt[l] = DVW'(trial - {1'b0, div_in});
          lq_nxt[l]  = {lq_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[DVW-1:0];
          lq_nxt[l]  = {lq_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        lq_r[s]   <= lq_nxt;
        div_r[s]  <= div_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = lq_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

>>> rtl/sdf_checker.sv
// ----------------------------------------------------------------------------
// sdf_checker: port-level checks of the spring/damper force block
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sdf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input sdf_pkg::sdf_in_t                  in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input sdf_pkg::sdf_out_t                 out_data,
  input logic                              cfg_we,
  input logic [sdf_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
  input logic [sdf_pkg::CFG_BITS-1:0]      cfg_wdata
);

  import sdf_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // a stalled output backs up into the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output is stalled");

  // coincident points give no force and the compressed branch
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.force_x == '0 && out_data.force_y == '0 &&
      out_data.force_z == '0 && !out_data.stretched)
    else $error("degenerate word carries force or stretch");

  // zero stiffness gives no force
  a_not_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.applied |->
      out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0)
    else $error("force present with zero stiffness");

endmodule

bind spring_damper_force_top sdf_checker u_sdf_checker (.*);

>>> tb/sdf_force_checker.sv
// ----------------------------------------------------------------------------
// sdf_force_checker: scoreboard for the spring/damper force block
// Mirrors the registers, predicts the force word of every accepted input
// word and compares every accepted result word field by field, in order.
// ----------------------------------------------------------------------------
module sdf_force_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  sdf_pkg::sdf_in_t                 in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  sdf_pkg::sdf_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [sdf_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [sdf_pkg::CFG_BITS-1:0]     cfg_wdata,
  output int                               fail_count,
  output int                               pending
);
  import sdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0]  LIM62   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]  ALL64   = '1;
  localparam logic [63:0]  OUT_POS = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]  OUT_NEG = 64'h0000_8000_0000_0000;

  logic [CFG_BITS-1:0] k_stretch, k_compress, damping_gain, rest_length;
  sdf_out_t            force_q[$];
  int                  errors;

  assign fail_count = errors;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // floor square root of a 128-bit value
  function automatic logic [63:0] isqrt(input logic [127:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  // quotient saturated to 64 bits
  function automatic logic [63:0] qsat(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] q;
    q = n / {64'd0, d};
    return (q[127:64] != 0) ? ALL64 : q[63:0];
  endfunction

  function automatic logic [63:0] mag64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // expected force word for one input word
  function automatic sdf_out_t spring_force(input sdf_in_t w);
    longint              dv[3], vv[3], s, t;
    logic [127:0]        dd, vmag, p;
    logic signed [127:0] vd;
    logic [63:0]         len, k, sq, m, qm, gm, tm, fm;
    logic                neg, qneg;
    sdf_out_t            r;
    dv[0] = longint'($signed(w.b_pos_x)) - longint'($signed(w.a_pos_x));
    dv[1] = longint'($signed(w.b_pos_y)) - longint'($signed(w.a_pos_y));
    dv[2] = longint'($signed(w.b_pos_z)) - longint'($signed(w.a_pos_z));
    vv[0] = longint'($signed(w.b_vel_x)) - longint'($signed(w.a_vel_x));
    vv[1] = longint'($signed(w.b_vel_y)) - longint'($signed(w.a_vel_y));
    vv[2] = longint'($signed(w.b_vel_z)) - longint'($signed(w.a_vel_z));
    dd = '0;
    vd = '0;
    for (int i = 0; i < 3; i++) begin
      dd = dd + {64'd0, mag64(dv[i])} * {64'd0, mag64(dv[i])};
      vd = vd + $signed({{64{vv[i][63]}}, vv[i]}) * $signed({{64{dv[i][63]}}, dv[i]});
    end
    len = isqrt(dd);
    r = '0;
    r.stretched  = len > {32'd0, rest_length};
    k = r.stretched ? {32'd0, k_stretch} : {32'd0, k_compress};
    r.applied    = k != 0;
    r.degenerate = dd == 0;
    if (!r.applied || r.degenerate) return r;
    // spring term
    s  = longint'(len) - longint'({32'd0, rest_length});
    p  = ({64'd0, mag64(s)} * {64'd0, mag64(s)}) >> FRAC_BITS;
    sq = (p[127:64] != 0) ? ALL64 : p[63:0];
    p  = ({64'd0, sq} * {64'd0, k}) >> FRAC_BITS;
    m  = (p > {64'd0, LIM62}) ? LIM62 : p[63:0];
    // damping term
    qneg = vd < 0;
    vmag = qneg ? 128'(-vd) : 128'(vd);
    qm   = qsat(vmag, len);
    p    = ({64'd0, 32'd0, damping_gain} * {64'd0, qm}) >> FRAC_BITS;
    gm   = (p > {64'd0, LIM62}) ? LIM62 : p[63:0];
    t    = qneg ? longint'(m) + longint'(gm) : longint'(m) - longint'(gm);
    tm   = mag64(t);
    // project on each axis, flip in the compressed branch, saturate
    for (int i = 0; i < 3; i++) begin
      fm  = qsat({64'd0, tm} * {64'd0, mag64(dv[i])}, len);
      neg = ((t < 0) != (dv[i] < 0)) != !r.stretched;
      if (neg) fm = (fm > OUT_NEG) ? OUT_NEG : fm;
      else     fm = (fm > OUT_POS) ? OUT_POS : fm;
      if (neg) fm = -fm;
      case (i)
        0: r.force_x = fm[FORCE_BITS-1:0];
        1: r.force_y = fm[FORCE_BITS-1:0];
        default: r.force_z = fm[FORCE_BITS-1:0];
      endcase
    end
    return r;
  endfunction

  // register mirror, prediction and comparison
  always @(posedge clk) begin
    sdf_out_t e;
    if (!rst_n) begin
      k_stretch    <= K_RESET;
      k_compress   <= K_RESET;
      damping_gain <= '0;
      rest_length  <= '0;
      force_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_K_STRETCH:    k_stretch    <= cfg_wdata;
          REG_K_COMPRESS:   k_compress   <= cfg_wdata;
          REG_DAMPING_GAIN: damping_gain <= cfg_wdata;
          REG_REST_LENGTH:  rest_length  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) force_q.push_back(spring_force(in_data));
      if (out_valid && !out_stall) begin
        if (force_q.size() == 0) begin
          report("unexpected word", 64'(out_data), 64'd0);
        end else begin
          e = force_q.pop_front();
          if (out_data.force_x !== e.force_x)
            report("force_x", 64'(out_data.force_x), 64'(e.force_x));
          if (out_data.force_y !== e.force_y)
            report("force_y", 64'(out_data.force_y), 64'(e.force_y));
          if (out_data.force_z !== e.force_z)
            report("force_z", 64'(out_data.force_z), 64'(e.force_z));
          if (out_data.applied !== e.applied)
            report("applied", 64'(out_data.applied), 64'(e.applied));
          if (out_data.degenerate !== e.degenerate)
            report("degenerate", 64'(out_data.degenerate), 64'(e.degenerate));
          if (out_data.stretched !== e.stretched)
            report("stretched", 64'(out_data.stretched), 64'(e.stretched));
        end
      end
      pending = force_q.size();
    end
  end

endmodule

>>> tb/tb_spring_damper_force_top.sv
// ----------------------------------------------------------------------------
// tb_spring_damper_force_top: testbench of the spring/damper force block
// Directed corner words, then register phases with random words, all but the
// last under random idle bursts on both sides; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_spring_damper_force_top;
  import sdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN      = 200;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  sdf_in_t                 in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  sdf_out_t                out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_addr = REG_K_STRETCH;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;
  int                      fail_count, pending;
  logic                    gaps_on = 1'b1;
  int                      idle_cycles = 0;
  int                      stall_left = 0;
  logic [31:0]             cur_rest = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  spring_damper_force_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  sdf_force_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_addr, .cfg_wdata, .fail_count, .pending
  );

  // receiver stall in random bursts
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("spring_damper_force_top test failed");
      $finish;
    end
  end

  // send one word, with an optional idle burst first
  task automatic send_word(input sdf_in_t w);
    logic st;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    forever begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
      if (!st) break;
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] ks, input logic [31:0] kc,
                            input logic [31:0] dg, input logic [31:0] rl);
    logic [31:0] v[4];
    v = '{ks, kc, dg, rl};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_IDX_BITS'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    cur_rest = rl;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 3))
      0: return SMIN;
      1: return SMAX;
      2: return 32'd0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [31:0] small_val(input int bits);
    return 32'($signed(32'($urandom_range(0, (1 << bits) - 1))) - (1 << (bits - 1)));
  endfunction

  // random word: mostly well-scaled springs, plus full range, coincident, near-rest and edges
  function automatic sdf_in_t rand_word();
    sdf_in_t w;
    int      sel;
    sel = $urandom_range(0, 9);
    w.a_pos_x = small_val(24); w.a_pos_y = small_val(24); w.a_pos_z = small_val(24);
    w.b_pos_x = w.a_pos_x + small_val(21);
    w.b_pos_y = w.a_pos_y + small_val(21);
    w.b_pos_z = w.a_pos_z + small_val(21);
    w.a_vel_x = small_val(20); w.a_vel_y = small_val(20); w.a_vel_z = small_val(20);
    w.b_vel_x = small_val(20); w.b_vel_y = small_val(20); w.b_vel_z = small_val(20);
    case (sel)
      6: w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      7: begin
        w.b_pos_x = w.a_pos_x; w.b_pos_y = w.a_pos_y; w.b_pos_z = w.a_pos_z;
      end
      8: begin
        // length close to the rest length along x
        w.b_pos_x = w.a_pos_x + cur_rest + small_val(4);
        w.b_pos_y = w.a_pos_y; w.b_pos_z = w.a_pos_z;
      end
      9: begin
        w.a_pos_x = pick_edge(); w.a_pos_y = pick_edge(); w.a_pos_z = pick_edge();
        w.b_pos_x = pick_edge(); w.b_pos_y = pick_edge(); w.b_pos_z = pick_edge();
        w.a_vel_x = pick_edge(); w.b_vel_y = pick_edge(); w.b_vel_z = pick_edge();
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    sdf_in_t w;
    logic [31:0] ks, kc, dg, rl;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, coincident points, extremes of every field
    send_word('0);
    send_word({12{SMIN}});
    send_word({{3{SMIN}}, {3{SMAX}}, {3{SMIN}}, {3{SMAX}}});
    send_word({{3{SMAX}}, {3{SMIN}}, {3{SMAX}}, {3{SMIN}}});
    send_word({{3{32'd0}}, 32'h0001_0000, 64'd0, {3{32'd0}}, {3{32'd0}}});
    send_word({{3{32'd0}}, 32'd1, 64'd0, {6{32'd0}}});
    send_word({{3{32'd0}}, 32'hFFFF_0000, 64'd0, SMAX, 64'd0, SMIN, 64'd0});
    drain_words();

    // directed: damping on, rest length 5.0, compressed and stretched branches
    write_regs(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0005_0000);
    send_word({{3{32'd0}}, 32'h0002_0000, 64'd0, {3{32'd0}}, 32'h0001_0000, 64'd0});
    send_word({{3{32'd0}}, 32'h0005_0000, 64'd0, {6{32'd0}}});
    send_word({{3{32'd0}}, 32'h0009_0000, 64'd0, 32'h0004_0000, 64'd0, {3{32'd0}}});
    send_word({{3{32'd0}}, 32'h0009_0000, 64'd0, {3{32'd0}}, SMAX, 64'd0});
    send_word('0);
    drain_words();

    // directed: every register at its maximum, then zero stiffness
    write_regs('1, '1, '1, '1);
    send_word({{3{SMIN}}, {3{SMAX}}, {3{SMAX}}, {3{SMIN}}});
    send_word({{3{32'd0}}, 32'h0001_0000, 64'd0, {6{32'd0}}});
    drain_words();
    write_regs('1, '1, '1, '0);
    send_word({{3{SMIN}}, {3{SMAX}}, {3{SMAX}}, {3{SMIN}}});
    send_word({{3{SMAX}}, {3{SMIN}}, {3{SMIN}}, {3{SMAX}}});
    drain_words();
    write_regs('0, '0, 32'h0001_0000, 32'h0002_0000);
    send_word({{3{32'd0}}, 32'h0001_0000, 64'd0, {6{32'd0}}});
    send_word({{3{32'd0}}, 32'h0004_0000, 64'd0, {6{32'd0}}});
    send_word('0);
    drain_words();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin ks = K_RESET; kc = K_RESET; dg = '0; rl = '0; end
        1: begin ks = '0; kc = $urandom; dg = $urandom; rl = $urandom_range(0, 32'h0010_0000); end
        2: begin ks = $urandom; kc = '0; dg = $urandom; rl = $urandom_range(0, 32'h0010_0000); end
        3: begin ks = '1; kc = '1; dg = '1; rl = '1; end
        4: begin ks = '1; kc = '1; dg = '0; rl = 32'h0040_0000; end
        default: begin
          ks = $urandom_range(0, 32'h00FF_FFFF);
          kc = $urandom_range(0, 32'h00FF_FFFF);
          dg = $urandom_range(0, 32'h000F_FFFF);
          rl = $urandom_range(0, 32'h0020_0000);
        end
      endcase
      write_regs(ks, kc, dg, rl);
      if (ph == 9) gaps_on = 1'b0;
      for (int n = 0; n < 100; n++) begin
        w = rand_word();
        send_word(w);
        // the sender holds off once until the pipeline is empty
        if (ph == 5 && n == 50) drain_words();
      end
      drain_words();
    end

    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("spring_damper_force_top test passed");
    end else begin
      $display("spring_damper_force_top test failed");
    end
    $finish;
  end

endmodule
